FILE: rtl/core/orthonormal_line_euler_update_core_macros.svh
// Assertion macros for the line update core.
`ifndef ORTHONORMAL_LINE_EULER_UPDATE_CORE_MACROS_SVH
`define ORTHONORMAL_LINE_EULER_UPDATE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OLU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define OLU_ASSERT(lbl, clk, rstn, prop, msg)
`define OLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/core/olu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package olu_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int KW = $clog2(CORDIC_STAGES);
  localparam int SQ_STEPS = 32;
  localparam int AW = 36;
  localparam int EW = 34;
  localparam int PW = 2 * EW;
  localparam int SW = PW + 2;
  localparam int QW = 32;
  localparam int RW = 64;

  typedef logic signed [EW-1:0] ent_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [PW-1:0] prd_t;
  typedef logic signed [QW-1:0] sin_t;
  typedef ent_t mat_t [3][3];

  typedef struct packed {
    logic flag;
    ent_t x;
    ent_t y;
    ang_t z;
  } rot_t;

  typedef struct packed {
    logic flag;
    ang_t x;
    ang_t y;
    ang_t z;
  } vec_t;

  typedef struct packed {
    logic [RW-1:0] v;
    logic [RW-1:0] r;
  } sqr_t;

  typedef struct packed {
    ent_t s;
    ent_t c;
  } trig_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam ang_t PI_Q30 = AW'(64'sd3373259426);
  localparam ang_t HALF_PI_Q30 = AW'(64'sd1686629713);
  localparam ent_t GAIN_Q30 = EW'(64'sd652032874);
  localparam ent_t ONE_Q30 = EW'(64'sd1073741824);
  localparam sin_t ONE_S = QW'(64'sd1073741824);
  localparam logic [RW-1:0] ONE_Q60 = RW'(1) << 60;
  localparam logic signed [SW-1:0] HALF30 = SW'(64'sd536870912);
  localparam ang_t HALF15 = AW'(64'sd16384);
  localparam ang_t FULL_LIM = AW'(64'sd102944);
  localparam ang_t HALF_LIM = AW'(64'sd51472);

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  function automatic ang_t atan_val(int k);
    return ang_t'({{(AW-30){1'b0}}, ATAN_TAB[k]});
  endfunction

  function automatic mat_t rot_mat(logic [1:0] axis, ent_t s, ent_t c);
    mat_t r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r[i][j] = '0;
      end
    end
    case (axis)
      AX_X: begin
        r[0][0] = ONE_Q30; r[1][1] = c; r[2][2] = c; r[1][2] = -s; r[2][1] = s;
      end
      AX_Y: begin
        r[1][1] = ONE_Q30; r[2][2] = c; r[0][0] = c; r[2][0] = -s; r[0][2] = s;
      end
      AX_Z: begin
        r[2][2] = ONE_Q30; r[0][0] = c; r[1][1] = c; r[0][1] = -s; r[1][0] = s;
      end
      default: begin
        r[0][0] = '0;
      end
    endcase
    return r;
  endfunction

  function automatic ent_t rnd30(logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    if (v >= 0) begin
      t = (v + HALF30) >>> 30;
    end else begin
      t = -((-v + HALF30) >>> 30);
    end
    return t[EW-1:0];
  endfunction

  function automatic sin_t sat_one(ent_t v);
    sin_t r;
    if (v > ONE_Q30) begin
      r = ONE_S;
    end else if (v < -ONE_Q30) begin
      r = -ONE_S;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic ang_t rnd15(ang_t v);
    ang_t r;
    if (v >= 0) begin
      r = (v + HALF15) >>> 15;
    end else begin
      r = -((-v + HALF15) >>> 15);
    end
    return r;
  endfunction

  function automatic ang_t sat_ang(ang_t v, ang_t lim);
    ang_t r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/olu_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface olu_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] roll;
  logic signed [17:0] pitch;
  logic signed [17:0] yaw;
  logic signed [17:0] line_angle;
  logic signed [17:0] delta_roll;
  logic signed [17:0] delta_pitch;
  logic signed [17:0] delta_yaw;
  logic signed [17:0] delta_line_angle;

  modport source (
    output valid, roll, pitch, yaw, line_angle,
    output delta_roll, delta_pitch, delta_yaw, delta_line_angle,
    input  ready
  );
  modport sink (
    input  valid, roll, pitch, yaw, line_angle,
    input  delta_roll, delta_pitch, delta_yaw, delta_line_angle,
    output ready
  );
endinterface

interface olu_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] new_roll;
  logic signed [16:0] new_pitch;
  logic signed [17:0] new_yaw;
  logic signed [16:0] new_line_angle;

  modport source (
    output valid, new_roll, new_pitch, new_yaw, new_line_angle,
    input  ready
  );
  modport sink (
    input  valid, new_roll, new_pitch, new_yaw, new_line_angle,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/olu_rot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module olu_rot_cell import olu_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [KW-1:0] k_i,
  input  ang_t          atan_i,
  input  rot_t          d_i,
  output rot_t          d_o
);
  ent_t x, y, xs, ys;
  ang_t z;
  rot_t d_d, d_q;

  always_comb begin
    x = d_i.x;
    y = d_i.y;
    z = d_i.z;
    xs = x >>> k_i;
    ys = y >>> k_i;
    d_d.flag = d_i.flag;
    if (z >= 0) begin
      d_d.x = x - ys;
      d_d.y = y + xs;
      d_d.z = z - atan_i;
    end else begin
      d_d.x = x + ys;
      d_d.y = y - xs;
      d_d.z = z + atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule
`default_nettype wire

FILE: rtl/core/olu_vec_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module olu_vec_cell import olu_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [KW-1:0] k_i,
  input  ang_t          atan_i,
  input  vec_t          d_i,
  output vec_t          d_o
);
  ang_t x, y, z, xs, ys;
  vec_t d_d, d_q;

  always_comb begin
    x = d_i.x;
    y = d_i.y;
    z = d_i.z;
    xs = x >>> k_i;
    ys = y >>> k_i;
    d_d.flag = d_i.flag;
    if (y < 0) begin
      d_d.x = x - ys;
      d_d.y = y + xs;
      d_d.z = z - atan_i;
    end else begin
      d_d.x = x + ys;
      d_d.y = y - xs;
      d_d.z = z + atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule
`default_nettype wire

FILE: rtl/core/olu_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module olu_sqrt_cell import olu_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [5:0] sh_i,
  input  sqr_t       d_i,
  output sqr_t       d_o
);
  logic [RW-1:0] b, t;
  sqr_t d_d, d_q;

  always_comb begin
    b = RW'(1) << sh_i;
    t = d_i.r + b;
    if (d_i.v >= t) begin
      d_d.v = d_i.v - t;
      d_d.r = (d_i.r >> 1) + b;
    end else begin
      d_d.v = d_i.v;
      d_d.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule
`default_nettype wire

FILE: rtl/core/orthonormal_line_euler_update_core.sv
// Throughput: one beat per cycle while the output is not stalled; every CORDIC step,
// matrix product and square-root digit is its own pipeline stage, and the output register
// frees the pipe while a beat waits.
// Reset: rst_ni clears all valid flags and the output valid; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "orthonormal_line_euler_update_core_macros.svh"
module orthonormal_line_euler_update_core import olu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  olu_in_if.sink    in_i,
  olu_out_if.source out_o
);
  localparam int NV = 2 * CORDIC_STAGES + 44;
  localparam int DD = SQ_STEPS + 1;

  logic          pipe_en;
  logic [NV-1:0] vld_q;

  logic signed [17:0] angv [8];
  rot_t  rpre [8];
  rot_t  rch  [8][CORDIC_STAGES];
  trig_t trig_q [9][8];

  mat_t  opa [5];
  mat_t  opb [5];
  prd_t  prod_q [5][3][3][3];
  ent_t  mat_q [5][3][3];
  prd_t  lprod_q [2];
  ent_t  sl_q;

  sin_t  sfr [2];
  logic signed [RW-1:0] sq_q [2];
  sin_t  sdl_q [DD][2];
  ent_t  mdl_q [DD][4];
  sqr_t  sqpre [2];
  sqr_t  sqch  [2][SQ_STEPS];

  vec_t  vpre [4];
  vec_t  vch  [4][CORDIC_STAGES];
  ang_t  zr [4];

  logic               out_valid_q;
  logic signed [17:0] new_roll_q, new_yaw_q;
  logic signed [16:0] new_pitch_q, new_line_angle_q;

  assign pipe_en = !vld_q[NV-1] || !out_valid_q || out_o.ready;
  assign in_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NV-2:0], in_i.valid};
    end
  end

  // sine/cosine front end
  assign angv[0] = in_i.roll;
  assign angv[1] = in_i.pitch;
  assign angv[2] = in_i.yaw;
  assign angv[3] = in_i.line_angle;
  assign angv[4] = in_i.delta_roll;
  assign angv[5] = in_i.delta_pitch;
  assign angv[6] = in_i.delta_yaw;
  assign angv[7] = in_i.delta_line_angle;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      ang_t a;
      a = AW'(angv[c]) <<< 15;
      rpre[c].x = GAIN_Q30;
      rpre[c].y = '0;
      if (a > HALF_PI_Q30) begin
        rpre[c].z = a - PI_Q30;
        rpre[c].flag = 1'b1;
      end else if (a < -HALF_PI_Q30) begin
        rpre[c].z = a + PI_Q30;
        rpre[c].flag = 1'b1;
      end else begin
        rpre[c].z = a;
        rpre[c].flag = 1'b0;
      end
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_rch
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      if (i == 0) begin : g_first
        olu_rot_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .k_i (KW'(i)), .atan_i (atan_val(i)),
          .d_i (rpre[c]), .d_o (rch[c][i])
        );
      end else begin : g_next
        olu_rot_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .k_i (KW'(i)), .atan_i (atan_val(i)),
          .d_i (rch[c][i-1]), .d_o (rch[c][i])
        );
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int c = 0; c < 8; c++) begin
        if (rch[c][CORDIC_STAGES-1].flag) begin
          trig_q[0][c].s <= -rch[c][CORDIC_STAGES-1].y;
          trig_q[0][c].c <= -rch[c][CORDIC_STAGES-1].x;
        end else begin
          trig_q[0][c].s <= rch[c][CORDIC_STAGES-1].y;
          trig_q[0][c].c <= rch[c][CORDIC_STAGES-1].x;
        end
      end
      for (int d = 1; d < 9; d++) begin
        trig_q[d] <= trig_q[d-1];
      end
    end
  end

  // matrix chain: Rz(yaw) Ry(pitch) Rx(roll) Rx(dr) Ry(dp) Rz(dy)
  always_comb begin
    opa[0] = rot_mat(AX_Z, trig_q[0][2].s, trig_q[0][2].c);
    opb[0] = rot_mat(AX_Y, trig_q[0][1].s, trig_q[0][1].c);
    opa[1] = mat_q[0];
    opb[1] = rot_mat(AX_X, trig_q[2][0].s, trig_q[2][0].c);
    opa[2] = mat_q[1];
    opb[2] = rot_mat(AX_X, trig_q[4][4].s, trig_q[4][4].c);
    opa[3] = mat_q[2];
    opb[3] = rot_mat(AX_Y, trig_q[6][5].s, trig_q[6][5].c);
    opa[4] = mat_q[3];
    opb[4] = rot_mat(AX_Z, trig_q[8][6].s, trig_q[8][6].c);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int m = 0; m < 5; m++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
              prod_q[m][i][j][k] <= opa[m][i][k] * opb[m][k][j];
            end
            mat_q[m][i][j] <= rnd30(SW'(prod_q[m][i][j][0]) + SW'(prod_q[m][i][j][1])
                                    + SW'(prod_q[m][i][j][2]));
          end
        end
      end
      lprod_q[0] <= trig_q[8][3].s * trig_q[8][7].c;
      lprod_q[1] <= trig_q[8][3].c * trig_q[8][7].s;
      sl_q <= rnd30(SW'(lprod_q[0]) + SW'(lprod_q[1]));
    end
  end

  // asin front: square, then one root digit per stage
  assign sfr[0] = sat_one(-mat_q[4][2][0]);
  assign sfr[1] = sat_one(sl_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int c = 0; c < 2; c++) begin
        sq_q[c] <= sfr[c] * sfr[c];
        sdl_q[0][c] <= sfr[c];
      end
      mdl_q[0][0] <= mat_q[4][2][1];
      mdl_q[0][1] <= mat_q[4][2][2];
      mdl_q[0][2] <= mat_q[4][1][0];
      mdl_q[0][3] <= mat_q[4][0][0];
      for (int d = 1; d < DD; d++) begin
        sdl_q[d] <= sdl_q[d-1];
        mdl_q[d] <= mdl_q[d-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sqpre[c].v = ONE_Q60 - sq_q[c];
      sqpre[c].r = '0;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_sch
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      if (j == 0) begin : g_first
        olu_sqrt_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .sh_i (6'(62 - 2 * j)),
          .d_i (sqpre[c]), .d_o (sqch[c][j])
        );
      end else begin : g_next
        olu_sqrt_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .sh_i (6'(62 - 2 * j)),
          .d_i (sqch[c][j-1]), .d_o (sqch[c][j])
        );
      end
    end
  end

  // arctangent chains: roll, pitch, yaw, line angle
  always_comb begin
    ang_t vy [4];
    ang_t vx [4];
    vy[0] = AW'(mdl_q[DD-1][0]);
    vx[0] = AW'(mdl_q[DD-1][1]);
    vy[1] = AW'(sdl_q[DD-1][0]);
    vx[1] = AW'($signed({1'b0, sqch[0][SQ_STEPS-1].r[30:0]}));
    vy[2] = AW'(mdl_q[DD-1][2]);
    vx[2] = AW'(mdl_q[DD-1][3]);
    vy[3] = AW'(sdl_q[DD-1][1]);
    vx[3] = AW'($signed({1'b0, sqch[1][SQ_STEPS-1].r[30:0]}));
    for (int c = 0; c < 4; c++) begin
      vpre[c].flag = (vx[c] == 0) && (vy[c] == 0);
      if (vx[c] < 0) begin
        vpre[c].z = (vy[c] >= 0) ? PI_Q30 : -PI_Q30;
        vpre[c].x = -vx[c];
        vpre[c].y = -vy[c];
      end else begin
        vpre[c].z = '0;
        vpre[c].x = vx[c];
        vpre[c].y = vy[c];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_vch
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      if (i == 0) begin : g_first
        olu_vec_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .k_i (KW'(i)), .atan_i (atan_val(i)),
          .d_i (vpre[c]), .d_o (vch[c][i])
        );
      end else begin : g_next
        olu_vec_cell u_cell (
          .clk_i (clk_i), .en_i (pipe_en), .k_i (KW'(i)), .atan_i (atan_val(i)),
          .d_i (vch[c][i-1]), .d_o (vch[c][i])
        );
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      zr[c] = vch[c][CORDIC_STAGES-1].flag ? '0 : rnd15(vch[c][CORDIC_STAGES-1].z);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en && vld_q[NV-1]) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && vld_q[NV-1]) begin
      new_roll_q       <= 18'(sat_ang(zr[0], FULL_LIM));
      new_pitch_q      <= 17'(sat_ang(zr[1], HALF_LIM));
      new_yaw_q        <= 18'(sat_ang(zr[2], FULL_LIM));
      new_line_angle_q <= 17'(sat_ang(zr[3], HALF_LIM));
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.new_roll       = new_roll_q;
  assign out_o.new_pitch      = new_pitch_q;
  assign out_o.new_yaw        = new_yaw_q;
  assign out_o.new_line_angle = new_line_angle_q;

  `OLU_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (vld_q[NV-1] && out_valid_q && !out_o.ready) |-> !in_i.ready, "input taken while last stage is blocked")
  `OLU_ASSERT(a_drain_frees_input, clk_i, rst_ni, (!vld_q[NV-1] || out_o.ready) |-> in_i.ready, "pipe stalled without cause")
  `OLU_ASSERT_NEXT(a_beat_enters, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0], "accepted beat lost at entry")
  `OLU_ASSERT(a_pitch_range, clk_i, rst_ni, out_o.valid |-> (out_o.new_pitch <= 17'sd51472 && out_o.new_pitch >= -17'sd51472), "pitch out of range")
endmodule
`default_nettype wire
